[rtl/core/pcle_pkg.sv]
// ----------------------------------------------------------------------------
// pcle_pkg
// Shared types and constants of the capability list engine: command and
// error codes, engine states, and the item that passes from front to back.
// ----------------------------------------------------------------------------
package pcle_pkg;

  localparam int SPACE_BYTES_DEF = 256;
  localparam int MAX_HOPS_DEF    = 64;
  localparam int ADDR_SPAN       = 1 << 8;

  localparam logic [7:0] PTR_MASK     = 8'hFC;
  localparam logic [7:0] MIN_CAP_ADDR = 8'h40;
  localparam logic [7:0] ALIGN_BITS   = 8'h03;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_LINK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_ADDR = 2'd1,
    ERR_TOO_LONG = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WALK
  } state_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] address;
    logic [7:0] write_data;
    logic [7:0] cap_id;
    logic       bad_link;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctrl_t;

endpackage

[rtl/core/pcle_ram.sv]
// ----------------------------------------------------------------------------
// pcle_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module pcle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra_addr,
  output logic [WIDTH-1:0]                    ra_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rb_addr,
  output logic [WIDTH-1:0]                    rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

[rtl/core/pcle_front.sv]
// ----------------------------------------------------------------------------
// pcle_front
// Command front end: accepts transactions, classifies link offsets and
// queues items for the back end.
// ----------------------------------------------------------------------------
module pcle_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic [1:0]          command,
  input  logic [7:0]          address,
  input  logic [7:0]          write_data,
  input  logic [7:0]          cap_id,
  input  pcle_pkg::back_ctrl_t ctrl,
  output pcle_pkg::queue_t    q
);
  import pcle_pkg::*;

  item_t          ent [QDEPTH];
  item_t          new_item;
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;

  assign cmd_stall = ctrl.clearing || (count == QCW'(QDEPTH));
  assign push      = cmd_valid && !cmd_stall;

  always_comb begin
    new_item.command    = cmd_t'(command);
    new_item.address    = address;
    new_item.write_data = write_data;
    new_item.cap_id     = cap_id;
    new_item.bad_link   = (address < MIN_CAP_ADDR) || ((address & ALIGN_BITS) != 8'h00);
  end

  assign q.valid = (count != '0);
  assign q.item  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (ctrl.pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      case ({push, ctrl.pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= new_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

[rtl/core/pcle_back.sv]
// ----------------------------------------------------------------------------
// pcle_back
// Execution back end: owns the configuration byte store, the list flag and
// head, walks the capability list one hop per cycle and holds the result.
// ----------------------------------------------------------------------------
module pcle_back #(
  parameter int SPACE_BYTES = pcle_pkg::SPACE_BYTES_DEF,
  parameter int MAX_HOPS    = pcle_pkg::MAX_HOPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pcle_pkg::queue_t     q,
  output pcle_pkg::back_ctrl_t ctrl,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [7:0]           read_data,
  output logic [1:0]           error_code
);
  import pcle_pkg::*;

  localparam int DEPTH = (SPACE_BYTES < ADDR_SPAN) ? SPACE_BYTES : ADDR_SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW    = $clog2(MAX_HOPS + 1);

  function automatic logic in_store(input logic [7:0] a);
    return 9'(a) < 9'(DEPTH);
  endfunction

  state_t        state;
  state_t        state_next;
  logic [AW-1:0] clr_idx;
  item_t         item;
  logic [7:0]    cur;
  logic [HW-1:0] hops;
  logic          a_ok;
  logic          b_ok;
  logic          present;
  logic [7:0]    head;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ra_data;
  logic [7:0]    rb_data;
  logic [7:0]    issue_ptr;
  logic [7:0]    issue_next;

  logic          can_start;
  logic [7:0]    head_ptr;
  logic [7:0]    a_byte;
  logic [7:0]    b_byte;
  logic [7:0]    nxt;
  logic [7:0]    link_ptr;
  logic          hit;
  logic          last_hop;
  logic          walk_done;

  logic          pop;
  logic          issue;
  logic          hops_load;
  logic          hops_dec;
  logic          set_head;
  logic          res_load;
  logic [7:0]    res_data;
  err_t          res_err;

  assign can_start  = (state == ST_IDLE) && q.valid && !rsp_valid;
  assign head_ptr   = head & PTR_MASK;
  assign a_byte     = a_ok ? ra_data : 8'h00;
  assign b_byte     = b_ok ? rb_data : 8'h00;
  assign nxt        = b_byte & PTR_MASK;
  assign link_ptr   = {cur[7:2], 2'b01};
  assign issue_next = {issue_ptr[7:2], 2'b01};
  assign hit        = (item.command == CMD_FIND) && (a_byte == item.cap_id);
  assign last_hop   = (hops == HW'(1));
  assign walk_done  = hit || (nxt == 8'h00) || last_hop;

  assign ctrl.pop      = pop;
  assign ctrl.clearing = (state == ST_CLEAR);

  pcle_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_addr (issue_ptr[AW-1:0]),
    .ra_data (ra_data),
    .rb_addr (issue_next[AW-1:0]),
    .rb_data (rb_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (can_start) begin
          case (q.item.command)
            CMD_READ: state_next = ST_READ;
            CMD_FIND: begin
              if (present && head_ptr != 8'h00) begin
                state_next = ST_WALK;
              end
            end
            CMD_LINK: begin
              if (!q.item.bad_link && head_ptr != 8'h00) begin
                state_next = ST_WALK;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_WALK: begin
        if (walk_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    issue     = 1'b0;
    issue_ptr = 8'h00;
    hops_load = 1'b0;
    hops_dec  = 1'b0;
    set_head  = 1'b0;
    res_load  = 1'b0;
    res_data  = 8'h00;
    res_err   = ERR_NONE;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = 8'h00;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
      end
      ST_IDLE: begin
        if (can_start) begin
          pop = 1'b1;
          case (q.item.command)
            CMD_READ: begin
              issue     = 1'b1;
              issue_ptr = q.item.address;
            end
            CMD_WRITE: begin
              ram_we    = in_store(q.item.address);
              ram_waddr = q.item.address[AW-1:0];
              ram_wdata = q.item.write_data;
              res_load  = 1'b1;
            end
            CMD_FIND: begin
              if (present && head_ptr != 8'h00) begin
                issue     = 1'b1;
                issue_ptr = head_ptr;
                hops_load = 1'b1;
              end else begin
                res_load = 1'b1;
              end
            end
            CMD_LINK: begin
              if (q.item.bad_link) begin
                res_load = 1'b1;
                res_err  = ERR_BAD_ADDR;
              end else if (head_ptr == 8'h00) begin
                set_head = 1'b1;
                res_load = 1'b1;
              end else begin
                issue     = 1'b1;
                issue_ptr = head_ptr;
                hops_load = 1'b1;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        res_load = 1'b1;
        res_data = a_byte;
      end
      ST_WALK: begin
        if (item.command == CMD_FIND) begin
          if (hit) begin
            res_load = 1'b1;
            res_data = cur;
          end else if (nxt == 8'h00 || last_hop) begin
            res_load = 1'b1;
          end
        end else if (nxt == 8'h00) begin
          ram_we    = in_store(link_ptr);
          ram_waddr = link_ptr[AW-1:0];
          ram_wdata = item.address;
          res_load  = 1'b1;
        end else if (last_hop) begin
          res_load = 1'b1;
          res_err  = ERR_TOO_LONG;
        end
        if (!walk_done) begin
          issue     = 1'b1;
          issue_ptr = nxt;
          hops_dec  = 1'b1;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      present   <= 1'b0;
      head      <= 8'h00;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (set_head) begin
        present <= 1'b1;
        head    <= q.item.address;
      end
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= q.item;
    end
    if (issue) begin
      cur  <= issue_ptr;
      a_ok <= in_store(issue_ptr);
      b_ok <= in_store(issue_next);
    end
    if (hops_load) begin
      hops <= HW'(MAX_HOPS);
    end else if (hops_dec) begin
      hops <= hops - HW'(1);
    end
    if (res_load) begin
      read_data  <= res_data;
      error_code <= res_err;
    end
  end

  a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !rsp_valid)
    else $error("response during store clear");

  a_walk_ptr: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> (cur != 8'h00) && (cur[1:0] == 2'b00) && (hops != '0))
    else $error("walk with bad pointer or exhausted hop count");

  a_start_slot_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> !rsp_valid && state == ST_IDLE)
    else $error("item started while result slot busy");

endmodule

[rtl/core/pci_capability_list_engine.sv]
// ----------------------------------------------------------------------------
// pci_capability_list_engine
// Configuration space byte store with a linked capability list: read and
// write bytes, find a capability by id, link a new capability at the tail.
// ----------------------------------------------------------------------------
// After reset the store is cleared one byte per cycle, covering
// min(SPACE_BYTES, 256) bytes; no command is taken until that pass is done.
// Each command then yields exactly one response. A read goes from the front
// queue through the read state to the response register, and a write loads
// the response register directly; find and link walk the list one entry
// per hop, visiting at most MAX_HOPS entries, where each hop is one paired
// read of the id byte and the next pointer from the store. A two-entry queue
// keeps taking commands while a result waits in the response register.
// ----------------------------------------------------------------------------
module pci_capability_list_engine #(
  parameter int SPACE_BYTES = pcle_pkg::SPACE_BYTES_DEF,
  parameter int MAX_HOPS    = pcle_pkg::MAX_HOPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] command,
  input  logic [7:0] address,
  input  logic [7:0] write_data,
  input  logic [7:0] cap_id,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data,
  output logic [1:0] error_code
);
  import pcle_pkg::*;

  queue_t     q;
  back_ctrl_t ctrl;

  pcle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .address    (address),
    .write_data (write_data),
    .cap_id     (cap_id),
    .ctrl       (ctrl),
    .q          (q)
  );

  pcle_back #(
    .SPACE_BYTES (SPACE_BYTES),
    .MAX_HOPS    (MAX_HOPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q          (q),
    .ctrl       (ctrl),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_data  (read_data),
    .error_code (error_code)
  );

endmodule
